// ----- rtl/wip_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wip_pkg - shared types and constants of the weighted isotonic projection
// Field widths, shared-unit step counts and the unit's control/status types.
// ---------------------------------------------------------------------------
package wip_pkg;

  localparam int VAL_W  = 32;  // sample and projected value
  localparam int MASS_W = 24;  // element mass
  localparam int SUM_W  = 64;  // block weighted sum
  localparam int WGT_W  = 30;  // block weight
  localparam int ERR_W  = 31;  // momentum error
  localparam int HALF_W = 29;  // half block weight
  localparam int ACC_W  = 96;  // shared unit accumulator
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 96;

  // cross product takes two steps per weight bit, divide one step per quotient bit
  localparam int MUL_STEPS = 2 * WGT_W;
  localparam int DIV_STEPS = VAL_W;

  typedef struct packed {
    logic start;
    logic div_mode;
  } wip_alu_ctl_t;

  typedef struct packed {
    logic done;
    logic gt;
  } wip_alu_sts_t;

endpackage

// ----- rtl/wip_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wip_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ---------------------------------------------------------------------------
module wip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/wip_alu.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wip_alu - shared add/subtract unit for mean compare and rounding divide
// Compare mode: sa*wb - sb*wa, shift-add of sa then subtract of sb per weight bit, MSB first.
// Divide mode: 32-step restoring division of num by den.
// Operands must hold steady while the unit is busy.
// ---------------------------------------------------------------------------
module wip_alu (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wip_pkg::wip_alu_ctl_t              ctl,
  input  logic signed [wip_pkg::SUM_W-1:0]   sa,
  input  logic        [wip_pkg::WGT_W-1:0]   wa,
  input  logic signed [wip_pkg::SUM_W-1:0]   sb,
  input  logic        [wip_pkg::WGT_W-1:0]   wb,
  input  logic        [wip_pkg::SUM_W-1:0]   num,
  input  logic        [wip_pkg::WGT_W:0]     den,
  output wip_pkg::wip_alu_sts_t              sts,
  output logic        [wip_pkg::VAL_W-1:0]   quo,
  output logic        [wip_pkg::WGT_W:0]     rem
);
  import wip_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [5:0]       step_r;
  logic             busy_r, mode_r, done_r;
  logic [ACC_W-1:0] op_a, op_b, sum;
  logic             cin;
  logic [4:0]       bitsel;
  logic [VAL_W-1:0] part_rem;
  logic             fits;
  logic             last_step;

  // weight bit under work, most significant first
  assign bitsel   = 5'(WGT_W - 1) - step_r[5:1];
  assign part_rem = {acc_r[62:32], acc_r[31]};

  // operand selection for the single adder
  always_comb begin
    op_a = '0;
    op_b = '0;
    cin  = 1'b0;
    if (mode_r) begin
      op_a = {{(ACC_W-VAL_W){1'b0}}, part_rem};
      op_b = ~{{(ACC_W-WGT_W-1){1'b0}}, den};
      cin  = 1'b1;
    end else if (!step_r[0]) begin
      op_a = {acc_r[ACC_W-2:0], 1'b0};
      op_b = wb[bitsel] ? {{(ACC_W-SUM_W){sa[SUM_W-1]}}, sa} : '0;
    end else begin
      op_a = acc_r;
      op_b = wa[bitsel] ? ~{{(ACC_W-SUM_W){sb[SUM_W-1]}}, sb} : '0;
      cin  = wa[bitsel];
    end
  end

  assign sum  = op_a + op_b + {{(ACC_W-1){1'b0}}, cin};
  assign fits = !sum[ACC_W-1];

  always_comb begin
    if (mode_r) begin
      acc_nxt = {{(ACC_W-64){1'b0}}, fits ? sum[VAL_W-1:0] : part_rem, acc_r[30:0], fits};
    end else begin
      acc_nxt = sum;
    end
  end

  assign last_step = mode_r ? (step_r == 6'(DIV_STEPS - 1)) : (step_r == 6'(MUL_STEPS - 1));

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      mode_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        mode_r <= ctl.div_mode;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 6'd1;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= ctl.div_mode ? {{(ACC_W-SUM_W){1'b0}}, num} : '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.gt   = !acc_r[ACC_W-1] && (|acc_r);
  assign quo      = acc_r[VAL_W-1:0];
  assign rem      = acc_r[62:32];

endmodule

// ----- rtl/weighted_isotonic_projection.sv -----
`timescale 1ns / 1ps
// Each accepted element is loaded and pushed. Unless the block stack is
// empty, its mean is then compared with the top block on the shared
// add/subtract unit in a 60-step compare. Each pooling that leaves a block
// below the merged one adds a stack read and a further compare. After the
// element flagged last, each block goes through a stack read, operand set-up
// and a 32-step divide before its results leave at one per cycle, stalled by
// out_tready. in_tready is low from acceptance until the element is pooled, or
// until the last result is taken; a full chain drops further elements but
// still honours their last flag.
// ---------------------------------------------------------------------------
// weighted_isotonic_projection - weighted pool-adjacent-violators solver
// Block stack in RAM with the top block in registers; shared unit compares
// and divides.
// ---------------------------------------------------------------------------
module weighted_isotonic_projection #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wip_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] sample_value,
                                                         // [55:32] sample_mass
  input  logic                               in_tlast,   // last_element
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wip_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [31:0] projected_value,
                                                         // [62:32] peak rounding error,
                                                         // [91:63] peak half weight,
                                                         // [95:92] zero
  output logic                               out_tlast   // last_result
);
  import wip_pkg::*;

  localparam int IDXW  = $clog2(MAX_ELEMENTS);
  localparam int CNTW  = IDXW + 1;
  localparam int WORDW = CNTW + WGT_W + SUM_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_PUSH  = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_E_RD  = 4'd5;
  localparam logic [3:0] S_E_LD  = 4'd6;
  localparam logic [3:0] S_E_GO  = 4'd7;
  localparam logic [3:0] S_E_DIV = 4'd8;
  localparam logic [3:0] S_E_OUT = 4'd9;

  logic [3:0]               state_r, state_nxt;
  logic [CNTW-1:0]          bcnt_r, ecnt_r, blk_r, elem_r;
  logic signed [VAL_W-1:0]  nv_r;
  logic [MASS_W-1:0]        nm_r;
  logic                     nlast_r, casc_r;
  logic signed [SUM_W-1:0]  n_sum_r, top_sum_r;
  logic [WGT_W-1:0]         top_w_r, bw_r;
  logic [CNTW-1:0]          top_stop_r, bstop_r;
  logic [SUM_W-1:0]         u_r;
  logic                     neg_r;
  logic [VAL_W-1:0]         mean_r;
  logic [ERR_W-1:0]         max_err_r;
  logic [HALF_W-1:0]        max_half_r;

  logic                     wr_en, rd_en;
  logic [IDXW-1:0]          wr_addr, rd_addr;
  logic [WORDW-1:0]         wr_data, rd_data;
  logic signed [SUM_W-1:0]  ram_sum;
  logic [WGT_W-1:0]         ram_w;
  logic [CNTW-1:0]          ram_stop;

  wip_alu_ctl_t             alu_ctl;
  wip_alu_sts_t             alu_sts;
  logic [VAL_W-1:0]         alu_quo;
  logic [WGT_W:0]           alu_rem;
  logic signed [SUM_W-1:0]  cmp_sa, cmp_sb;
  logic [WGT_W-1:0]         cmp_wa, cmp_wb;

  logic                     top_blk, last_res;
  logic signed [SUM_W-1:0]  src_sum, rnd_num;
  logic [WGT_W-1:0]         src_w;
  logic [CNTW-1:0]          src_stop;
  logic [WGT_W:0]           dd, r_adj;
  logic signed [VAL_W-1:0]  diff;
  logic [VAL_W-1:0]         adiff;
  logic [ERR_W-1:0]         blk_err;
  logic [MASS_W-1:0]        in_mass;
  logic signed [VAL_W+MASS_W:0] n_prod;

  assign {ram_stop, ram_w, ram_sum} = rd_data;
  assign in_mass = (in_tdata[55:32] == '0) ? MASS_W'(1) : in_tdata[55:32];

  // block stack below the top block
  wip_ram #(.WIDTH(WORDW), .DEPTH(MAX_ELEMENTS)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // compare operands: below block against the block above it
  assign cmp_sa = casc_r ? ram_sum   : top_sum_r;
  assign cmp_wa = casc_r ? ram_w     : top_w_r;
  assign cmp_sb = casc_r ? top_sum_r : n_sum_r;
  assign cmp_wb = casc_r ? top_w_r   : WGT_W'(nm_r);

  wip_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .sa    (cmp_sa),
    .wa    (cmp_wa),
    .sb    (cmp_sb),
    .wb    (cmp_wb),
    .num   (u_r),
    .den   ({bw_r, 1'b0}),
    .sts   (alu_sts),
    .quo   (alu_quo),
    .rem   (alu_rem)
  );

  // weighted sum of the incoming singleton, full product width
  assign n_prod = nv_r * $signed({1'b0, nm_r});

  // emit-side block source and rounding numerator 2s + w - 1
  assign top_blk  = (blk_r == bcnt_r - CNTW'(1));
  assign src_sum  = top_blk ? top_sum_r  : ram_sum;
  assign src_w    = top_blk ? top_w_r    : ram_w;
  assign src_stop = top_blk ? top_stop_r : ram_stop;
  assign rnd_num  = (src_sum <<< 1) + $signed({{(SUM_W-WGT_W){1'b0}}, src_w})
                    - SUM_W'(1);

  // rounding error of the block from the divide remainder
  assign dd      = {bw_r, 1'b0};
  assign r_adj   = neg_r ? (dd - (WGT_W+1)'(1) - alu_rem) : alu_rem;
  assign diff    = $signed(VAL_W'(bw_r)) - $signed(VAL_W'(1)) - $signed(VAL_W'(r_adj));
  assign adiff   = diff[VAL_W-1] ? VAL_W'(-diff) : VAL_W'(diff);
  assign blk_err = adiff[ERR_W:1];

  assign last_res = top_blk && (elem_r + CNTW'(1) == bstop_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    alu_ctl     = '0;
    wr_en       = 1'b0;
    wr_addr     = IDXW'(bcnt_r - CNTW'(1));
    wr_data     = {top_stop_r, top_w_r, top_sum_r};
    rd_en       = 1'b0;
    rd_addr     = IDXW'(bcnt_r - CNTW'(2));
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (ecnt_r == CNTW'(MAX_ELEMENTS)) state_nxt = nlast_r ? S_E_RD : S_IDLE;
        else state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (bcnt_r == '0) begin
          state_nxt = nlast_r ? S_E_RD : S_IDLE;
        end else begin
          alu_ctl.start = 1'b1;
          state_nxt     = S_CMP;
        end
      end
      S_CMP: begin
        if (alu_sts.done) begin
          if (alu_sts.gt) begin
            if (casc_r) rd_addr = IDXW'(bcnt_r - CNTW'(3));
            if ((casc_r && bcnt_r >= CNTW'(3)) || (!casc_r && bcnt_r >= CNTW'(2))) begin
              rd_en     = 1'b1;
              state_nxt = S_RD;
            end else begin
              state_nxt = nlast_r ? S_E_RD : S_IDLE;
            end
          end else begin
            wr_en     = !casc_r;
            state_nxt = nlast_r ? S_E_RD : S_IDLE;
          end
        end
      end
      S_RD: begin
        alu_ctl.start = 1'b1;
        state_nxt     = S_CMP;
      end
      S_E_RD: begin
        rd_en     = 1'b1;
        rd_addr   = IDXW'(blk_r);
        state_nxt = S_E_LD;
      end
      S_E_LD: state_nxt = S_E_GO;
      S_E_GO: begin
        alu_ctl.start    = 1'b1;
        alu_ctl.div_mode = 1'b1;
        state_nxt        = S_E_DIV;
      end
      S_E_DIV: begin
        if (alu_sts.done) state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        if (out_tready && elem_r + CNTW'(1) == bstop_r) begin
          state_nxt = top_blk ? S_IDLE : S_E_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bcnt_r  <= '0;
      ecnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD && ecnt_r != CNTW'(MAX_ELEMENTS)) begin
        ecnt_r <= ecnt_r + CNTW'(1);
      end
      if (state_r == S_PUSH && bcnt_r == '0) begin
        bcnt_r <= CNTW'(1);
      end
      if (state_r == S_CMP && alu_sts.done) begin
        if (alu_sts.gt && casc_r) bcnt_r <= bcnt_r - CNTW'(1);
        if (!alu_sts.gt && !casc_r) bcnt_r <= bcnt_r + CNTW'(1);
      end
      if (state_r == S_E_OUT && out_tready && last_res) begin
        bcnt_r <= '0;
        ecnt_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      nv_r    <= in_tdata[31:0];
      nm_r    <= in_mass;
      nlast_r <= in_tlast;
    end
    if (state_r == S_LOAD) begin
      n_sum_r <= SUM_W'(n_prod);
    end
    if (state_r == S_PUSH) begin
      casc_r <= 1'b0;
      if (bcnt_r == '0) begin
        top_sum_r  <= n_sum_r;
        top_w_r    <= WGT_W'(nm_r);
        top_stop_r <= ecnt_r;
      end
    end
    if (state_r == S_CMP && alu_sts.done) begin
      if (alu_sts.gt) begin
        casc_r <= 1'b1;
        if (casc_r) begin
          top_sum_r <= top_sum_r + ram_sum;
          top_w_r   <= top_w_r + ram_w;
        end else begin
          top_sum_r  <= top_sum_r + n_sum_r;
          top_w_r    <= top_w_r + WGT_W'(nm_r);
          top_stop_r <= ecnt_r;
        end
      end else if (!casc_r) begin
        top_sum_r  <= n_sum_r;
        top_w_r    <= WGT_W'(nm_r);
        top_stop_r <= ecnt_r;
      end
    end
    // start of the emit pass
    if (state_nxt == S_E_RD && state_r != S_E_OUT) begin
      blk_r      <= '0;
      elem_r     <= '0;
      max_err_r  <= '0;
      max_half_r <= '0;
    end
    if (state_r == S_E_LD) begin
      neg_r   <= rnd_num[SUM_W-1];
      u_r     <= rnd_num[SUM_W-1] ? ~rnd_num : rnd_num;
      bw_r    <= src_w;
      bstop_r <= src_stop;
    end
    if (state_r == S_E_DIV && alu_sts.done) begin
      mean_r <= neg_r ? ~alu_quo : alu_quo;
      if (blk_err > max_err_r) max_err_r <= blk_err;
      if (bw_r[WGT_W-1:1] > max_half_r) max_half_r <= bw_r[WGT_W-1:1];
    end
    if (state_r == S_E_OUT && out_tready) begin
      elem_r <= elem_r + CNTW'(1);
      if (elem_r + CNTW'(1) == bstop_r) blk_r <= blk_r + CNTW'(1);
    end
  end

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_E_OUT);
  assign out_tlast  = last_res;
  assign out_tdata  = {4'b0,
                       last_res ? max_half_r : HALF_W'(0),
                       last_res ? max_err_r  : ERR_W'(0),
                       mean_r};

endmodule

// ----- rtl/wip_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wip_checker - port-level checks of the isotonic projection block
// Watches both stream channels; bound to the top level below.
// ---------------------------------------------------------------------------
module wip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tlast
);

  // hold a stalled result transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // never take an element while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during emit");

  // error and bound fields are zero except on the last result
  a_zero_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[95:32] == '0)
    else $error("statistics on a non-last result");

  // after the last result the block is ready again
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("block not idle after last result");

  // an accepted element produces no result in the next cycle
  a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result straight after acceptance");

endmodule

bind weighted_isotonic_projection wip_checker u_wip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - testbench of the weighted isotonic projection
// Feeds chains of weighted samples, predicts the pooled and rounded block
// means of each chain, and compares every result transfer field by field.
// ---------------------------------------------------------------------------
module tb;
  import wip_pkg::*;

  localparam int MAXN = 64;

  typedef struct packed {
    logic [28:0] half;
    logic [30:0] err;
    logic [31:0] mean;
    logic        last;
  } fit_t;

  typedef struct {
    logic [31:0] value;
    logic [23:0] mass;
    logic        last;
    logic        has_fit;
    fit_t        fit;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;   // [31:0] sample_value, [55:32] sample_mass
  logic         in_tlast;   // last_element
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // [31:0] projected_value, [62:32] peak rounding error,
                            // [91:63] peak half weight, [95:92] zero
  logic         out_tlast;  // last_result

  weighted_isotonic_projection #(.MAX_ELEMENTS(MAXN)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // predictor state: block stack of the current chain
  int              elem_cnt;
  int              blk_cnt;
  int              blk_len[MAXN];
  longint          blk_sum[MAXN];
  longint          blk_wgt[MAXN];
  fit_t            fit_q[$];
  int              mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // floor division by a positive weight
  function automatic void floor_div(input longint num, input longint w,
                                    output longint q, output longint r);
    q = num / w;
    r = num % w;
    if (r < 0) begin
      r += w;
      q -= 1;
    end
  endfunction

  // exact sa/wa > sb/wb
  function automatic bit mean_gt(longint sa, longint wa, longint sb, longint wb);
    longint qa, qb, ra, rb;
    floor_div(sa, wa, qa, ra);
    floor_div(sb, wb, qb, rb);
    if (qa != qb) return qa > qb;
    return ra * wb > rb * wa;
  endfunction

  // push one element, pool violators, and on the last one queue the fits
  function automatic void pool_element(logic [31:0] value, logic [23:0] mass_in,
                                       logic last);
    longint m, q, r, diff, e, max_err, max_half;
    fit_t f;
    m = (mass_in == 0) ? 1 : longint'(mass_in);
    if (elem_cnt < MAXN) begin
      blk_len[blk_cnt] = 1;
      blk_wgt[blk_cnt] = m;
      blk_sum[blk_cnt] = m * longint'(signed'(value));
      blk_cnt++;
      elem_cnt++;
      while (blk_cnt >= 2 && mean_gt(blk_sum[blk_cnt-2], blk_wgt[blk_cnt-2],
                                     blk_sum[blk_cnt-1], blk_wgt[blk_cnt-1])) begin
        blk_len[blk_cnt-2] += blk_len[blk_cnt-1];
        blk_sum[blk_cnt-2] += blk_sum[blk_cnt-1];
        blk_wgt[blk_cnt-2] += blk_wgt[blk_cnt-1];
        blk_cnt--;
      end
    end
    if (!last) return;
    max_err = 0;
    max_half = 0;
    for (int b = 0; b < blk_cnt; b++) begin
      floor_div(blk_sum[b], blk_wgt[b], q, r);
      if (r * 2 > blk_wgt[b]) q += 1;
      diff = q * blk_wgt[b] - blk_sum[b];
      e = diff < 0 ? -diff : diff;
      if (e > max_err) max_err = e;
      if (blk_wgt[b] / 2 > max_half) max_half = blk_wgt[b] / 2;
      for (int k = 0; k < blk_len[b]; k++) begin
        f = '0;
        f.mean = q[31:0];
        fit_q.insert(fit_q.size(), f);
      end
    end
    if (fit_q.size() > 0) begin
      f = fit_q.pop_back();
      f.err = max_err[30:0];
      f.half = max_half[28:0];
      f.last = 1'b1;
      fit_q.insert(fit_q.size(), f);
    end
    blk_cnt = 0;
    elem_cnt = 0;
  endfunction

  // no gap or a short one mostly, sometimes a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one element; valid drops only during a gap before it
  task automatic send(logic [31:0] value, logic [23:0] mass, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata  <= {mass, value};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pool_element(value, mass, last);
    @(negedge clk);
  endtask

  // random chain: wild values, a falling trend with noise, small values or alternating extremes
  task automatic send_chain(int len);
    logic [31:0] v;
    logic [23:0] m;
    int base, mode;
    mode = $urandom_range(0, 3);
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom;
        1: v = base - i * $urandom_range(0, 5000) + $urandom_range(0, 300);
        2: v = $urandom_range(0, 15) - 8;
        default: v = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      case ($urandom_range(0, 4))
        0: m = 24'hFF_FFFF;
        1: m = 24'($urandom_range(0, 3));
        default: m = 24'($urandom);
      endcase
      send(v, m, i == len - 1);
    end
  endtask

  // compare each result transfer with the oldest expected fit
  always @(posedge clk) begin
    fit_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mean = out_tdata[31:0];
      got.err  = out_tdata[62:32];
      got.half = out_tdata[91:63];
      got.last = out_tlast;
      if (fit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = fit_q.pop_front();
        if (got !== want || out_tdata[95:92] !== 4'h0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: mean %h/%h err %h/%h half %h/%h last %b/%b",
                     want.mean, got.mean, want.err, got.err,
                     want.half, got.half, want.last, got.last);
        end
      end
    end
  end

  // random stall on the result side
  initial begin
    int g;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= 1'b1;
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    int   wait_cnt;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    mismatches = 0;
    elem_cnt = 0;
    blk_cnt = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: single extremes with fits read off at a glance, then pooling
    r = '{32'h7FFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1,
          '{29'h7F_FFFF, 31'd0, 32'h7FFF_FFFF, 1'b1}};
    dir.insert(dir.size(), r);
    r = '{32'h8000_0000, 24'd1, 1'b1, 1'b1, '{29'd0, 31'd0, 32'h8000_0000, 1'b1}};
    dir.insert(dir.size(), r);
    // zero mass is taken as one
    r = '{32'd5, 24'd0, 1'b1, 1'b1, '{29'd0, 31'd0, 32'd5, 1'b1}};
    dir.insert(dir.size(), r);
    // decreasing pair pools; tie goes down: (3+0)/2 -> 1
    r = '{32'd3, 24'd1, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'd0, 24'd1, 1'b1, 1'b0, '0}; dir.insert(dir.size(), r);
    // negative chain: -3 pools with the minimum; equal-mass extremes tie at -1/2 -> -1
    r = '{-32'sd3, 24'd1, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'h8000_0000, 24'd2, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'h8000_0000, 24'hFF_FFFF, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'd0, 24'h80_0001, 1'b1, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'd10, 24'd3, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'd20, 24'd5, 1'b0, 1'b0, '0}; dir.insert(dir.size(), r);
    r = '{32'd15, 24'd7, 1'b1, 1'b0, '0}; dir.insert(dir.size(), r);
    foreach (dir[i]) begin
      if (dir[i].has_fit && dir[i].last) begin
        send(dir[i].value, dir[i].mass, 1'b1);
        void'(fit_q.pop_back());
        fit_q.insert(fit_q.size(), dir[i].fit);
      end else begin
        send(dir[i].value, dir[i].mass, dir[i].last);
      end
    end

    // full chain with overflow drops, last flag on a dropped item
    for (int i = 0; i < MAXN + 3; i++)
      send($urandom, 24'($urandom_range(1, 24'hFF_FFFF)), i == MAXN + 2);

    // random chains, mostly short
    wait_cnt = 0;
    while (wait_cnt < 220) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAXN)
                                        : $urandom_range(1, 8);
      send_chain(len);
      wait_cnt += len;
    end
    in_tvalid <= 1'b0;

    while (fit_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
